// ===== rtl/core/fly_camera_move_update_unit_defines.svh =====
// Assertion macros shared by the fly camera checker.
`ifndef FLY_CAMERA_MOVE_UPDATE_UNIT_DEFINES_SVH
`define FLY_CAMERA_MOVE_UPDATE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FCMU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fcmu assertion failed");

// Next-cycle implication, disabled during reset.
`define FCMU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fcmu assertion failed");

`endif

// ===== rtl/core/fcmu_pkg.sv =====
// Package for the fly camera move update unit: constants, codes and state type.
package fcmu_pkg;

    localparam int POS_FRAC_BITS  = 16;
    localparam int UNIT_BITS      = 30;
    localparam int STEP_FRAC_BITS = 24;
    localparam int MV_SHIFT       = UNIT_BITS + STEP_FRAC_BITS - POS_FRAC_BITS;
    localparam int MV_W           = 66 - MV_SHIFT;
    localparam int SUM_W          = ((MV_W > 32) ? MV_W : 32) + 1;

    localparam logic signed [15:0] UP_X_RST  = 16'sd0;
    localparam logic signed [15:0] UP_Y_RST  = 16'sd16384;
    localparam logic signed [15:0] UP_Z_RST  = 16'sd0;
    localparam logic [15:0]        SPEED_RST = 16'd2560;
    localparam logic signed [31:0] LOOK_Z_RST = -(32'sd1 <<< POS_FRAC_BITS);

    typedef enum logic [1:0] {
        CFG_UP_X  = 2'd0,
        CFG_UP_Y  = 2'd1,
        CFG_UP_Z  = 2'd2,
        CFG_SPEED = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NSHIFT,
        S_SQ,
        S_SQACC,
        S_SQRT,
        S_DLOAD,
        S_DIV,
        S_XMUL,
        S_XACC,
        S_STEP,
        S_STEPW,
        S_MMUL,
        S_MACC,
        S_UPD,
        S_EMIT
    } t_state;

endpackage

// ===== rtl/core/fly_camera_move_update_unit.sv =====
// Fly camera move update: iterative normalize, cross product and point update.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall | delta_time, four move flags
//  out     | output    | o_out_valid / i_out_stall | eye_x/y/z, target_x/y/z
//  cfg     | input     | i_cfg_wr_en            | i_cfg_idx, i_cfg_wr_data
//
// Each of the two normalizations runs a one-bit-per-cycle square root and three
// one-bit-per-cycle divides plus a variable alignment shift.
// The input stalls while an item is in work; the finished result sits in an
// output register, so a new transfer is taken while it waits.
// Synchronous active-low reset returns points and configuration registers to their defaults.
module fly_camera_move_update_unit
    import fcmu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [15:0]        i_delta_time,
    input  logic               i_move_left,
    input  logic               i_move_right,
    input  logic               i_move_forward,
    input  logic               i_move_back,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_eye_x,
    output logic signed [31:0] o_eye_y,
    output logic signed [31:0] o_eye_z,
    output logic signed [31:0] o_target_x,
    output logic signed [31:0] o_target_y,
    output logic signed [31:0] o_target_z
);

    t_state r_state, n_state;

    logic signed [15:0] r_up [3];
    logic [15:0]        r_speed;
    logic signed [31:0] r_eye [3];
    logic signed [31:0] r_look [3];
    logic signed [31:0] r_o_eye [3];
    logic signed [31:0] r_o_look [3];
    logic               r_ovalid;

    logic [15:0] r_dt;
    logic        r_rpos, r_rneg, r_fpos, r_fneg;
    logic        r_pass;
    logic [1:0]  r_k;
    logic [2:0]  r_j;
    logic [4:0]  r_cnt;

    logic [47:0] r_mag [3];
    logic        r_msg [3];
    logic [63:0] r_acc;
    logic [63:0] r_root;
    logic [63:0] r_bit;
    logic [31:0] r_len;
    logic [31:0] r_rem;
    logic [61:0] r_num;
    logic [30:0] r_quo;
    logic [31:0] r_fmg [3];
    logic        r_fsg [3];
    logic [31:0] r_rmg [3];
    logic        r_rsg [3];
    logic signed [47:0]     r_xacc;
    logic                   r_psg;
    logic [31:0]            r_step;
    logic signed [MV_W-1:0] r_mv;
    logic [63:0]            r_prod;

    logic        accept;
    logic        emit_ok;
    logic        all_zero, any_hi, all_lo;
    logic [63:0] sq_t, sq_root_nx;
    logic        sq_ge;
    logic [32:0] dv_t;
    logic        dv_ge;
    logic [61:0] dnum;
    logic [30:0] quo_nx;
    logic [31:0] mul_a, mul_b;
    logic [1:0]  xf_idx, xu_idx;
    logic [15:0] up_mag [3];
    logic signed [47:0] x_term, x_acc_nx;
    logic [47:0] x_abs;
    logic [63:0] mv_rnd;
    logic [MV_W-1:0] mv_mag;
    logic signed [MV_W-1:0] mv_term, mv_nx;
    logic        mv_pos, mv_neg, mv_vsg;
    logic [1:0]  jc;
    logic signed [31:0] eye_sat, look_sat;

    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] res;
        if (!v[SUM_W-1] && (|v[SUM_W-2:31])) begin
            res = 32'sh7FFF_FFFF;
        end else if (v[SUM_W-1] && !(&v[SUM_W-2:31])) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    assign accept  = i_in_valid && !o_in_stall;
    assign emit_ok = !r_ovalid || !i_out_stall;
    assign jc      = r_j[2:1];

    always_comb begin
        all_zero = 1'b1;
        any_hi   = 1'b0;
        all_lo   = 1'b1;
        for (int i = 0; i < 3; i++) begin
            all_zero = all_zero && (r_mag[i] == 48'd0);
            any_hi   = any_hi || (|r_mag[i][47:31]);
            all_lo   = all_lo && !(|r_mag[i][30:29]);
            up_mag[i] = r_up[i][15] ? (~r_up[i] + 16'd1) : r_up[i];
        end
    end

    assign sq_t       = r_root + r_bit;
    assign sq_ge      = r_acc >= sq_t;
    assign sq_root_nx = sq_ge ? ((r_root >> 1) + r_bit) : (r_root >> 1);

    assign dv_t   = {r_rem, r_num[61]};
    assign dv_ge  = dv_t >= {1'b0, r_len};
    assign quo_nx = {r_quo[29:0], dv_ge};
    assign dnum   = {1'b0, r_mag[r_k][30:0], 30'd0} + {31'd0, r_len[31:1]};

    // cross = fwd x up, one signed partial product per pair of steps
    always_comb begin
        unique case (r_j)
            3'd0:    begin xf_idx = 2'd1; xu_idx = 2'd2; end
            3'd1:    begin xf_idx = 2'd2; xu_idx = 2'd1; end
            3'd2:    begin xf_idx = 2'd2; xu_idx = 2'd0; end
            3'd3:    begin xf_idx = 2'd0; xu_idx = 2'd2; end
            3'd4:    begin xf_idx = 2'd0; xu_idx = 2'd1; end
            default: begin xf_idx = 2'd1; xu_idx = 2'd0; end
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_SQ:    begin mul_a = r_mag[r_k][31:0];    mul_b = r_mag[r_k][31:0]; end
            S_XMUL:  begin mul_a = r_fmg[xf_idx];       mul_b = {16'd0, up_mag[xu_idx]}; end
            S_STEP:  begin mul_a = {16'd0, r_dt};       mul_b = {16'd0, r_speed}; end
            S_MMUL:  begin mul_a = r_j[0] ? r_fmg[jc] : r_rmg[jc]; mul_b = r_step; end
            default: begin mul_a = 32'd0;               mul_b = 32'd0; end
        endcase
    end

    assign x_term   = $signed(r_prod[47:0]);
    assign x_acc_nx = r_j[0] ? (r_psg ? r_xacc - x_term : r_xacc + x_term)
                             : (r_psg ? -x_term : x_term);
    assign x_abs    = x_acc_nx[47] ? -x_acc_nx : x_acc_nx;

    assign mv_rnd  = r_prod + (64'd1 << (MV_SHIFT - 1));
    assign mv_mag  = MV_W'(mv_rnd >> MV_SHIFT);
    assign mv_pos  = r_j[0] ? r_fpos : r_rpos;
    assign mv_neg  = r_j[0] ? r_fneg : r_rneg;
    assign mv_vsg  = r_j[0] ? r_fsg[jc] : r_rsg[jc];
    assign mv_term = (mv_pos || mv_neg) ? ((mv_neg ^ mv_vsg) ? -$signed(mv_mag)
                                                             : $signed(mv_mag))
                                        : '0;
    assign mv_nx   = r_j[0] ? (r_mv + mv_term) : mv_term;

    assign eye_sat  = sat32(SUM_W'(r_eye[jc]) + SUM_W'(r_mv));
    assign look_sat = sat32(SUM_W'(r_look[jc]) + SUM_W'(r_mv));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:   if (accept) n_state = S_NSHIFT;
            S_NSHIFT: begin
                priority if (all_zero) begin
                    n_state = r_pass ? S_STEP : S_XMUL;
                end else if (any_hi || all_lo) begin
                    n_state = S_NSHIFT;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ:     n_state = S_SQACC;
            S_SQACC:  n_state = (r_k == 2'd2) ? S_SQRT : S_SQ;
            S_SQRT:   if (r_cnt == 5'd31) n_state = S_DLOAD;
            S_DLOAD:  n_state = S_DIV;
            S_DIV: begin
                if (r_cnt == 5'd30) begin
                    if (r_k == 2'd2) n_state = r_pass ? S_STEP : S_XMUL;
                    else             n_state = S_DLOAD;
                end
            end
            S_XMUL:   n_state = S_XACC;
            S_XACC:   n_state = (r_j == 3'd5) ? S_NSHIFT : S_XMUL;
            S_STEP:   n_state = S_STEPW;
            S_STEPW:  n_state = S_MMUL;
            S_MMUL:   n_state = S_MACC;
            S_MACC:   n_state = r_j[0] ? S_UPD : S_MMUL;
            S_UPD:    n_state = (r_j == 3'd5) ? S_EMIT : S_MMUL;
            S_EMIT:   if (emit_ok) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up[0]  <= UP_X_RST;
            r_up[1]  <= UP_Y_RST;
            r_up[2]  <= UP_Z_RST;
            r_speed  <= SPEED_RST;
            r_eye[0] <= '0;
            r_eye[1] <= '0;
            r_eye[2] <= '0;
            r_look[0] <= '0;
            r_look[1] <= '0;
            r_look[2] <= LOOK_Z_RST;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_UP_X:  r_up[0] <= i_cfg_wr_data;
                    CFG_UP_Y:  r_up[1] <= i_cfg_wr_data;
                    CFG_UP_Z:  r_up[2] <= i_cfg_wr_data;
                    CFG_SPEED: r_speed <= i_cfg_wr_data;
                endcase
            end
            if (r_state == S_UPD) begin
                r_eye[jc]  <= eye_sat;
                r_look[jc] <= look_sat;
            end
            if (r_state == S_EMIT && emit_ok) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_dt   <= i_delta_time;
                    r_rpos <= i_move_right && !i_move_left;
                    r_rneg <= i_move_left && !i_move_right;
                    r_fpos <= i_move_forward && !i_move_back;
                    r_fneg <= i_move_back && !i_move_forward;
                    r_pass <= 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        logic signed [32:0] d;
                        d = $signed({r_look[i][31], r_look[i]})
                          - $signed({r_eye[i][31], r_eye[i]});
                        r_msg[i] <= d[32];
                        r_mag[i] <= {15'd0, (d[32] ? -d : d)};
                    end
                end
            end
            S_NSHIFT: begin
                priority if (all_zero) begin
                    for (int i = 0; i < 3; i++) begin
                        if (r_pass) begin
                            r_rmg[i] <= '0;
                            r_rsg[i] <= 1'b0;
                        end else begin
                            r_fmg[i] <= '0;
                            r_fsg[i] <= 1'b0;
                        end
                    end
                    r_j <= 3'd0;
                end else if (any_hi) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                end else if (all_lo) begin
                    for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                end else begin
                    r_acc <= '0;
                    r_k   <= 2'd0;
                end
            end
            S_SQACC: begin
                r_acc <= r_acc + r_prod;
                r_k   <= r_k + 2'd1;
                if (r_k == 2'd2) begin
                    r_root <= '0;
                    r_bit  <= 64'd1 << 62;
                    r_cnt  <= '0;
                end
            end
            S_SQRT: begin
                if (sq_ge) r_acc <= r_acc - sq_t;
                r_root <= sq_root_nx;
                r_bit  <= r_bit >> 2;
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_len <= sq_root_nx[31:0];
                    r_k   <= 2'd0;
                end
            end
            S_DLOAD: begin
                r_rem <= {1'b0, dnum[61:31]};
                r_num <= {dnum[30:0], 31'd0};
                r_quo <= '0;
                r_cnt <= '0;
            end
            S_DIV: begin
                r_rem <= dv_ge ? 32'(dv_t - {1'b0, r_len}) : dv_t[31:0];
                r_num <= r_num << 1;
                r_quo <= quo_nx;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    if (r_pass) begin
                        r_rmg[r_k] <= {1'b0, quo_nx};
                        r_rsg[r_k] <= r_msg[r_k];
                    end else begin
                        r_fmg[r_k] <= {1'b0, quo_nx};
                        r_fsg[r_k] <= r_msg[r_k];
                    end
                    r_k <= r_k + 2'd1;
                    r_j <= 3'd0;
                end
            end
            S_XMUL: begin
                r_psg <= r_fsg[xf_idx] ^ r_up[xu_idx][15] ^ r_j[0];
            end
            S_XACC: begin
                r_xacc <= x_acc_nx;
                if (r_j[0]) begin
                    r_mag[jc] <= x_abs;
                    r_msg[jc] <= x_acc_nx[47];
                end
                if (r_j == 3'd5) r_pass <= 1'b1;
                r_j <= r_j + 3'd1;
            end
            S_STEPW: begin
                r_step <= r_prod[31:0];
                r_j    <= 3'd0;
            end
            S_MACC: begin
                r_mv <= mv_nx;
                if (!r_j[0]) r_j <= r_j + 3'd1;
            end
            S_UPD: begin
                r_j <= r_j + 3'd1;
            end
            S_EMIT: begin
                if (emit_ok) begin
                    for (int i = 0; i < 3; i++) begin
                        r_o_eye[i]  <= r_eye[i];
                        r_o_look[i] <= r_look[i];
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_eye_x     = r_o_eye[0];
    assign o_eye_y     = r_o_eye[1];
    assign o_eye_z     = r_o_eye[2];
    assign o_target_x  = r_o_look[0];
    assign o_target_y  = r_o_look[1];
    assign o_target_z  = r_o_look[2];

endmodule

// ===== rtl/core/fcmu_checker.sv =====
// Port-level checker for the fly camera move update unit, with its bind.
`include "fly_camera_move_update_unit_defines.svh"

module fcmu_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_eye_x,
    input logic signed [31:0] o_eye_y,
    input logic signed [31:0] o_eye_z,
    input logic signed [31:0] o_target_x,
    input logic signed [31:0] o_target_y,
    input logic signed [31:0] o_target_z
);

    logic         out_wait;
    logic [191:0] out_bus;

    assign out_wait = o_out_valid && i_out_stall;
    assign out_bus  = {o_eye_x, o_eye_y, o_eye_z, o_target_x, o_target_y, o_target_z};

    // a stalled result holds
    `FCMU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(out_bus))

    // an input transfer makes the block busy
    `FCMU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // finishing an item always leaves a result on the output
    `FCMU_ASSERT_NOW(a_done_has_result, i_clk, i_rst_n, $fell(o_in_stall), o_out_valid)

endmodule

bind fly_camera_move_update_unit fcmu_checker u_fcmu_checker (.*);
